// ===== sv/dbat_pkg.sv =====
// Shared types, constants and codes of the disk block allocation table.
package dbat_pkg;

	localparam int IDX_W           = 12;
	localparam int SECTOR_W        = 32;
	localparam int OFFSET_W        = 44;
	localparam int FP_W            = 41;
	localparam int END_W           = 42;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 41;
	localparam int TABLE_DEPTH_DEF = 4096;

	localparam logic [SECTOR_W-1:0] UNUSED_ENTRY = 32'hFFFF_FFFF;
	// 0xFFFFFFFF sectors of 512 bytes
	localparam logic [END_W-1:0]    ADDR_LIMIT   = 42'h1FF_FFFF_FE00;

	typedef enum logic [1:0] {
		OP_LOOKUP   = 2'd0,
		OP_ALLOCATE = 2'd1,
		OP_LOAD     = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNALLOC = 2'd1,
		ST_RANGE   = 2'd2,
		ST_OVERFLOW = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DYNAMIC_MODE  = 3'd0,
		CFG_BLOCK_LOG2    = 3'd1,
		CFG_BITMAP        = 3'd2,
		CFG_BITMAP_ALIGN  = 3'd3,
		CFG_BITMAP_PAD    = 3'd4,
		CFG_START_FREE    = 3'd5,
		CFG_ENTRIES       = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [IDX_W-1:0]       block_index;
		logic [SECTOR_W-1:0]    entry_sector;
	} req_t;

	typedef struct packed {
		logic [OFFSET_W-1:0]    data_offset;
		status_t                status;
		logic                   newly_allocated;
	} rsp_t;

endpackage

// ===== sv/disk_block_allocation_table_core.sv =====
// Disk block allocation table: block index to image byte offset, with allocation.
//
// Request channel (req_valid/req_stall/req) takes one item per cycle while
// req_stall is low: opcode, block index and a sector value for table loads.
// Each item gives exactly one item on the response channel
// (rsp_valid/rsp_stall/rsp): data offset, status and a newly-allocated flag.
// An accepted item is held in stage 1, then registered onto rsp, unless the
// previous response is still stalled there.
// One item per cycle while rsp is not stalled. The table read is registered at
// accept and the entry is written back as the item leaves stage 1; a write-to-read
// bypass in the table lets the next item see it, and the free pointer updates in place.
// When rsp is stalled the output register holds, the staged item waits and
// req_stall rises only once that stage is full.
// Reset: all control state clears and the table is swept to unused, one entry
// per cycle, over all TABLE_DEPTH entries (4096 by default); req_stall stays high
// for the sweep. Configuration writes are taken at any time, including then;
// writing start_free_address also loads the free pointer.
module disk_block_allocation_table_core #(
	parameter int TABLE_DEPTH = dbat_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  dbat_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output dbat_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [dbat_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dbat_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import dbat_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	// configuration
	logic                dynamic_q;
	logic [4:0]          block_log2_q;
	logic [19:0]         bitmap_q;
	logic [24:0]         bitmap_align_q;
	logic [24:0]         bitmap_pad_q;
	logic [12:0]         entries_q;
	logic [FP_W-1:0]     fp_q;

	// stage 1
	logic                s1_valid_q;
	opcode_t             opcode_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [SECTOR_W-1:0] sector_s1;
	logic [SECTOR_W-1:0] entry_s1;

	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic                busy;
	logic                accept;
	logic                s1_advance;
	logic [AW+IDX_W-1:0] rd_idx_wide;
	logic [AW+IDX_W-1:0] wr_idx_wide;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;

	// stage 1 evaluation
	logic                out_of_range;
	logic [31:0]         block_bytes;
	logic [END_W-1:0]    fp_aligned;
	logic [END_W-1:0]    alloc_end;
	logic [END_W-1:0]    pad_sum;
	logic [OFFSET_W-1:0] used_offset;
	logic [OFFSET_W-1:0] fixed_offset;
	logic                tbl_wr;
	logic [SECTOR_W-1:0] tbl_wdata;
	logic                do_alloc;
	rsp_t                rsp_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dynamic_q      <= 1'b1;
			block_log2_q   <= 5'd21;
			bitmap_q       <= 20'd512;
			bitmap_align_q <= 25'd4096;
			bitmap_pad_q   <= 25'd3584;
			entries_q      <= 13'd4096;
			fp_q           <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DYNAMIC_MODE: dynamic_q      <= cfg_wdata[0];
				CFG_BLOCK_LOG2:   block_log2_q   <= cfg_wdata[4:0];
				CFG_BITMAP:       bitmap_q       <= cfg_wdata[19:0];
				CFG_BITMAP_ALIGN: bitmap_align_q <= cfg_wdata[24:0];
				CFG_BITMAP_PAD:   bitmap_pad_q   <= cfg_wdata[24:0];
				CFG_START_FREE:   fp_q           <= cfg_wdata[FP_W-1:0];
				CFG_ENTRIES:      entries_q      <= cfg_wdata[12:0];
				default: ;
			endcase
		end else if (s1_advance && do_alloc) begin
			fp_q <= alloc_end[FP_W-1:0];
		end
	end

	assign s1_advance = s1_valid_q && (!rsp_valid_q || !rsp_stall);
	assign req_stall  = busy || (s1_valid_q && !s1_advance);
	assign accept     = req_valid && !req_stall;

	assign rd_idx_wide = (AW + IDX_W)'(req.block_index);
	assign wr_idx_wide = (AW + IDX_W)'(idx_s1);
	assign rd_addr     = rd_idx_wide[AW-1:0];
	assign wr_addr     = wr_idx_wide[AW-1:0];

	dbat_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.rd_data (entry_s1),
		.wr_en   (s1_advance && tbl_wr),
		.wr_addr (wr_addr),
		.wr_data (tbl_wdata),
		.busy    (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= req.opcode;
			idx_s1    <= req.block_index;
			sector_s1 <= req.entry_sector;
		end
	end

	always_comb begin
		out_of_range = ({1'b0, idx_s1} >= entries_q) || (32'(idx_s1) >= 32'(TABLE_DEPTH));
		block_bytes  = 32'd1 << block_log2_q;
		fp_aligned   = END_W'(fp_q) + END_W'(bitmap_align_q);
		alloc_end    = fp_aligned + END_W'(block_bytes);
		pad_sum      = END_W'(fp_q) + END_W'(bitmap_pad_q);
		used_offset  = OFFSET_W'({entry_s1, 9'b0}) + OFFSET_W'(bitmap_q);
		fixed_offset = OFFSET_W'(idx_s1) << block_log2_q;

		rsp_d     = '{data_offset: '0, status: ST_OK, newly_allocated: 1'b0};
		tbl_wr    = 1'b0;
		tbl_wdata = sector_s1;
		do_alloc  = 1'b0;

		if (out_of_range) begin
			rsp_d.status = ST_RANGE;
		end else if (opcode_s1 == OP_LOAD) begin
			tbl_wr = 1'b1;
		end else if (!dynamic_q) begin
			rsp_d.data_offset = fixed_offset;
		end else if (entry_s1 != UNUSED_ENTRY) begin
			rsp_d.data_offset = used_offset;
		end else if (opcode_s1 != OP_ALLOCATE) begin
			rsp_d.status = ST_UNALLOC;
		end else if (alloc_end > ADDR_LIMIT) begin
			rsp_d.status = ST_OVERFLOW;
		end else begin
			do_alloc                = 1'b1;
			tbl_wr                  = 1'b1;
			tbl_wdata               = pad_sum[40:9];
			rsp_d.data_offset       = OFFSET_W'(fp_aligned);
			rsp_d.newly_allocated   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_fp_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_advance && do_alloc && !cfg_we) |=> (fp_q > $past(fp_q)))
		else $error("free pointer did not advance on allocation");

	a_alloc_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.newly_allocated) |-> (rsp.status == ST_OK))
		else $error("allocation flagged with failing status");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_advance) |=> (s1_valid_q && $stable(idx_s1)))
		else $error("staged item lost while output stalled");
`endif

endmodule

// ===== sv/dbat_table.sv =====
// Sector table memory with clearing sweep after reset and write-to-read bypass.
module dbat_table #(
	parameter int TABLE_DEPTH = dbat_pkg::TABLE_DEPTH_DEF,
	localparam int AW = $clog2(TABLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [AW-1:0]                 rd_addr,
	output logic [dbat_pkg::SECTOR_W-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [AW-1:0]                 wr_addr,
	input  logic [dbat_pkg::SECTOR_W-1:0] wr_data,
	output logic                          busy
);
	import dbat_pkg::*;

	logic [SECTOR_W-1:0] mem [TABLE_DEPTH];
	logic                clr_q;
	logic [AW-1:0]       clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			if (clr_addr_q == AW'(TABLE_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_addr_q] <= UNUSED_ENTRY;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a write landing on the address being read wins
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

	assign busy = clr_q;

`ifndef ASSERT_OFF
	a_no_write_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !clr_q)
		else $error("item write during clearing sweep");

	a_no_read_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !clr_q)
		else $error("item read during clearing sweep");

	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |=> !clr_q)
		else $error("clearing sweep restarted outside reset");
`endif

endmodule
